// ===== hdl/sync_length_crc_frame_parser_assert.svh =====
// Assertion macros shared by the frame parser RTL.
// Needs no package; each macro takes its clock and active-low reset.
`ifndef SYNC_LENGTH_CRC_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_CRC_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, muted while reset is held.
`define SLCFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// Next-cycle implication, muted while reset is held.
`define SLCFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

// ===== hdl/slcfp_pkg.sv =====
// Shared types and constants of the sync/length/CRC frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package slcfp_pkg;

  localparam logic [7:0]  SYNC_BYTE    = 8'h5A;
  localparam logic [7:0]  HEADER_BYTES = 8'd8;
  localparam logic [15:0] MIN_LENGTH   = 16'd6;
  localparam logic [15:0] MAX_LENGTH   = 16'd128;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_SEED_RST = 16'hFFFF;

  // Header byte offsets that carry fields
  localparam logic [7:0] IDX_KIND_LO = 8'd2;
  localparam logic [7:0] IDX_KIND_HI = 8'd3;
  localparam logic [7:0] IDX_CMD     = 8'd4;
  localparam logic [7:0] IDX_SIZE_LO = 8'd6;
  localparam logic [7:0] IDX_SIZE_HI = 8'd7;

  // Event codes
  localparam logic [2:0] EV_IDLE    = 3'd0;
  localparam logic [2:0] EV_TAKEN   = 3'd1;
  localparam logic [2:0] EV_LEN_ERR = 3'd2;
  localparam logic [2:0] EV_CRC_ERR = 3'd3;
  localparam logic [2:0] EV_GOOD    = 3'd4;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_command;
    logic [15:0] frame_kind;
    logic [7:0]  frame_size;
  } result_t;

endpackage

// ===== hdl/slcfp_crc.sv =====
// One-byte CRC-16 CCITT update, MSB first.
// Depends on slcfp_pkg for the polynomial.
`timescale 1ns / 1ps

module slcfp_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import slcfp_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== hdl/slcfp_core.sv =====
// Parser state machine, header holds, running CRC and result formation.
// Depends on slcfp_pkg and slcfp_crc; assertion macros from the .svh header.
`timescale 1ns / 1ps
`include "sync_length_crc_frame_parser_assert.svh"

module slcfp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  input  logic              seed_wr,
  input  logic [15:0]       seed_data,
  output slcfp_pkg::result_t res
);
  import slcfp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] size_r, size_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] seed_r;
  logic [15:0] crc_upd;
  logic [16:0] body_end;
  logic        show;

  slcfp_crc u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= CRC_SEED_RST;
    end else if (seed_wr) begin
      seed_r <= seed_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      idx_r    <= '0;
      crc_r    <= CRC_SEED_RST;
      kind_r   <= '0;
      cmd_r    <= '0;
      size_r   <= '0;
      crc_lo_r <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      kind_r   <= kind_nxt;
      cmd_r    <= cmd_nxt;
      size_r   <= size_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  assign body_end = {1'b0, size_r} + 17'd2;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    kind_nxt   = kind_r;
    cmd_nxt    = cmd_r;
    size_nxt   = size_r;
    crc_lo_nxt = crc_lo_r;
    show       = 1'b1;
    res        = '0;

    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == SYNC_BYTE) begin
          phase_nxt  = PH_HEAD;
          idx_nxt    = 8'd1;
          crc_nxt    = seed_r;
          kind_nxt   = '0;
          cmd_nxt    = '0;
          size_nxt   = '0;
          crc_lo_nxt = '0;
          res.event_res = EV_TAKEN;
        end else begin
          show = 1'b0;
        end
      end
      PH_HEAD: begin
        if (idx_r >= IDX_KIND_LO) begin
          crc_nxt = crc_upd;
        end
        case (idx_r)
          IDX_KIND_LO: kind_nxt[7:0]  = rx_byte;
          IDX_KIND_HI: kind_nxt[15:8] = rx_byte;
          IDX_CMD:     cmd_nxt        = rx_byte;
          IDX_SIZE_LO: size_nxt[7:0]  = rx_byte;
          IDX_SIZE_HI: size_nxt[15:8] = rx_byte;
          default: ;
        endcase
        idx_nxt       = idx_r + 8'd1;
        res.event_res = EV_TAKEN;
        if (idx_nxt >= HEADER_BYTES) begin
          if (size_nxt < MIN_LENGTH || size_nxt > MAX_LENGTH) begin
            res.event_res = EV_LEN_ERR;
            phase_nxt     = PH_HUNT;
            idx_nxt       = '0;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if ({9'd0, idx_r} < body_end) begin
          crc_nxt           = crc_upd;
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte;
          res.event_res     = EV_TAKEN;
          idx_nxt           = idx_r + 8'd1;
        end else if ({9'd0, idx_r} == body_end) begin
          crc_lo_nxt    = rx_byte;
          res.event_res = EV_TAKEN;
          idx_nxt       = idx_r + 8'd1;
        end else begin
          res.event_res = ({rx_byte, crc_lo_r} == crc_r) ? EV_GOOD : EV_CRC_ERR;
          phase_nxt     = PH_HUNT;
          idx_nxt       = '0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        idx_nxt   = '0;
        show      = 1'b0;
      end
    endcase

    if (show) begin
      res.frame_command = cmd_nxt;
      res.frame_kind    = kind_nxt;
      res.frame_size    = (size_nxt[15:8] != 8'd0) ? 8'hFF : size_nxt[7:0];
    end
  end

  `SLCFP_ASSERT_IMP(a_body_len_ok, clk, rst_n, phase_r == PH_BODY, size_r >= MIN_LENGTH && size_r <= MAX_LENGTH)
  `SLCFP_ASSERT_IMP(a_head_idx, clk, rst_n, phase_r == PH_HEAD, idx_r >= 8'd1 && idx_r < HEADER_BYTES)
  `SLCFP_ASSERT_IMP(a_hunt_idx, clk, rst_n, phase_r == PH_HUNT, idx_r == 8'd0)

endmodule

// ===== hdl/slcfp_out.sv =====
// Result register of the frame parser; parts the input side from the result side.
// Depends on slcfp_pkg for the result word type.
`timescale 1ns / 1ps

module slcfp_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  slcfp_pkg::result_t res_in,
  input  logic               take,
  output logic               valid,
  output slcfp_pkg::result_t res_out
);
  import slcfp_pkg::*;

  logic    valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

// ===== hdl/sync_length_crc_frame_parser.sv =====
// Top level of the sync/length/CRC-16 frame parser.
// Depends on slcfp_pkg, slcfp_core, slcfp_out and the assertion macro header.
`timescale 1ns / 1ps
`include "sync_length_crc_frame_parser_assert.svh"

// The parser takes one received byte per input word and gives exactly one
// result word per byte, at a sustained rate of one word per clock cycle
// while the result side does not stall. A byte accepted at one edge has its
// result loaded into the output register at that same edge, so the result
// word can be taken at the next edge at the earliest; the path in front of
// the register is the one-byte CRC-16 CCITT update and the small phase state
// machine. It hunts for the 0x5A start byte, gathers the eight-byte header
// (sync, spare byte, little-endian type, command, reserved byte,
// little-endian length), rejects lengths below 6 or above 128, passes body
// bytes out as payload and checks the little-endian CRC that follows.
// The CRC covers header offset 2 up to the last body byte and starts from
// cfg_wr_data as last written (0xFFFF after reset). The input is stalled only
// while a finished result waits in the output register and the result side
// stalls; a word taken from the output lets a new byte in on the same edge.
// Write the seed only while the parser is idle. Event codes: 0 dropped,
// 1 byte taken, 2 length error, 3 CRC error, 4 frame good.
module sync_length_crc_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_frame_command,
  output logic [15:0] out_frame_kind,
  output logic [7:0]  out_frame_size,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import slcfp_pkg::*;

  logic    in_fire;
  logic    out_take;
  result_t core_res;
  result_t out_res;

  // Stall the input only when the result register is full and held.
  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign out_take = out_valid & ~out_stall;

  slcfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .rx_byte   (in_rx_byte),
    .seed_wr   (cfg_wr_en),
    .seed_data (cfg_wr_data),
    .res       (core_res)
  );

  slcfp_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_fire),
    .res_in  (core_res),
    .take    (out_take),
    .valid   (out_valid),
    .res_out (out_res)
  );

  // Spread the result word onto its ports
  assign out_event_res     = out_res.event_res;
  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_frame_command = out_res.frame_command;
  assign out_frame_kind    = out_res.frame_kind;
  assign out_frame_size    = out_res.frame_size;

  // An accepted byte always leaves a result waiting at the next edge.
  `SLCFP_ASSERT_NXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid)
  // Payload travels only with a byte-taken event.
  `SLCFP_ASSERT_IMP(a_payload_event, clk, rst_n, out_valid && out_payload_valid, out_event_res == EV_TAKEN)
  // A dropped byte shows no header fields.
  `SLCFP_ASSERT_IMP(a_idle_zero, clk, rst_n, out_valid && out_event_res == EV_IDLE, out_frame_command == 8'd0 && out_frame_kind == 16'd0 && out_frame_size == 8'd0)
  // A CRC verdict only ever follows a length in range.
  `SLCFP_ASSERT_IMP(a_verdict_len, clk, rst_n, out_valid && (out_event_res == EV_GOOD || out_event_res == EV_CRC_ERR), out_frame_size >= 8'd6 && out_frame_size <= 8'd128)

endmodule
